/* design/qrs_pkg.sv */
package qrs_pkg;

    localparam int COEF_W = 16;
    localparam int FRAC_W = 16;
    localparam int OUT_W  = 40;
    localparam int DISC_W = 33;
    localparam int RAD_W  = 66;
    localparam int ROOT_W = 33;
    localparam int REM_W  = 36;
    localparam int NUM_W  = 36;
    localparam int QUO_W  = 35;
    localparam int DIV_W  = 17;

    localparam logic [1:0] KIND_DISTINCT = 2'd0;
    localparam logic [1:0] KIND_EQUAL    = 2'd1;
    localparam logic [1:0] KIND_COMPLEX  = 2'd2;
    localparam logic [1:0] KIND_NONE     = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic [COEF_W-1:0] a;
        logic [COEF_W-1:0] b;
    } sq_side_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       neg1;
        logic       neg2;
    } dv_side_t;

endpackage

/* design/qrs_sqrt_cell.sv */
module qrs_sqrt_cell
    import qrs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              valid_in,
    input  logic [RAD_W-1:0]  x_in,
    input  logic [REM_W-1:0]  rem_in,
    input  logic [ROOT_W-1:0] root_in,
    input  sq_side_t          side_in,
    output logic              valid_out,
    output logic [RAD_W-1:0]  x_out,
    output logic [REM_W-1:0]  rem_out,
    output logic [ROOT_W-1:0] root_out,
    output sq_side_t          side_out
);

    logic              valid_reg;
    logic [RAD_W-1:0]  x_reg, x_next;
    logic [REM_W-1:0]  rem_reg, rem_next, rem_sh, trial;
    logic [ROOT_W-1:0] root_reg, root_next;
    sq_side_t          side_reg;

    always_comb
    begin
        rem_sh = {rem_in[REM_W-3:0], x_in[RAD_W-1:RAD_W-2]};
        trial  = {{(REM_W-ROOT_W-2){1'b0}}, root_in, 2'b01};
        x_next = {x_in[RAD_W-3:0], 2'b00};
        if (rem_sh >= trial)
        begin
            rem_next  = rem_sh - trial;
            root_next = {root_in[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = rem_sh;
            root_next = {root_in[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign x_out     = x_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;
    assign side_out  = side_reg;

endmodule

/* design/qrs_div_cell.sv */
module qrs_div_cell
    import qrs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             valid_in,
    input  logic [QUO_W-1:0] n1_in,
    input  logic [QUO_W-1:0] n2_in,
    input  logic [DIV_W-1:0] r1_in,
    input  logic [DIV_W-1:0] r2_in,
    input  logic [DIV_W-1:0] m_in,
    input  dv_side_t         side_in,
    output logic             valid_out,
    output logic [QUO_W-1:0] n1_out,
    output logic [QUO_W-1:0] n2_out,
    output logic [DIV_W-1:0] r1_out,
    output logic [DIV_W-1:0] r2_out,
    output logic [DIV_W-1:0] m_out,
    output dv_side_t         side_out
);

    logic             valid_reg;
    logic [QUO_W-1:0] n1_reg, n2_reg;
    logic [DIV_W-1:0] r1_reg, r2_reg, m_reg;
    logic [DIV_W:0]   t1, t2, mx;
    logic             ge1, ge2;
    dv_side_t         side_reg;

    always_comb
    begin
        mx  = {1'b0, m_in};
        t1  = {r1_in, n1_in[QUO_W-1]};
        t2  = {r2_in, n2_in[QUO_W-1]};
        ge1 = (t1 >= mx);
        ge2 = (t2 >= mx);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_reg   <= {n1_in[QUO_W-2:0], ge1};
            n2_reg   <= {n2_in[QUO_W-2:0], ge2};
            r1_reg   <= ge1 ? DIV_W'(t1 - mx) : t1[DIV_W-1:0];
            r2_reg   <= ge2 ? DIV_W'(t2 - mx) : t2[DIV_W-1:0];
            m_reg    <= m_in;
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign n1_out    = n1_reg;
    assign n2_out    = n2_reg;
    assign r1_out    = r1_reg;
    assign r2_out    = r2_reg;
    assign m_out     = m_reg;
    assign side_out  = side_reg;

endmodule

/* design/quadratic_root_solver.sv */
// Quadratic root solver: signed integer coefficients a, b, c in, one result
// beat out per input beat, with root_kind and two Q23.16 values.
// The input channel is coef_a, coef_b, coef_c with in_valid and in_ready.
// The output channel is root_kind, first_value, second_value with out_valid
// and out_ready. Both use a plain valid/ready handshake.
// A beat passes from acceptance to out_valid through one input register,
// a multiply stage, a discriminant stage, 33 square root cells (one root bit
// per cell), a numerator stage, 35 divider cells (one quotient bit per cell
// for both quotients) and the output register.
// The pipeline accepts one beat every cycle, so sustained throughput is one
// beat per cycle while out_ready stays high.
// When the receiver stalls with a result held in the output register, the
// whole pipeline holds and in_ready drops in the same cycle; it advances
// again as soon as out_ready returns or the output register empties.
// Reset clears every valid bit, so the block comes up empty with out_valid
// low and in_ready high; it resets no other state.
module quadratic_root_solver
    import qrs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [COEF_W-1:0] coef_a,
    input  logic signed [COEF_W-1:0] coef_b,
    input  logic signed [COEF_W-1:0] coef_c,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               root_kind,
    output logic signed [OUT_W-1:0]  first_value,
    output logic signed [OUT_W-1:0]  second_value
);

    logic en;

    logic              v0_reg;
    logic [COEF_W-1:0] a0_reg, b0_reg, c0_reg;

    logic              v1_reg;
    logic [31:0]       b2_reg;
    logic [33:0]       ac4_reg;
    logic              opp_reg;
    logic [COEF_W-1:0] a1_reg, b1_reg;
    logic [COEF_W-1:0] mag_a, mag_b, mag_c;

    logic              v2_reg;
    logic [DISC_W-1:0] d_reg, d_next;
    logic [1:0]        k2_reg, k2_next;
    logic [COEF_W-1:0] a2_reg, b2c_reg;
    logic [33:0]       b2x;

    logic              sv   [0:ROOT_W];
    logic [RAD_W-1:0]  sx   [0:ROOT_W];
    logic [REM_W-1:0]  srem [0:ROOT_W];
    logic [ROOT_W-1:0] sroot[0:ROOT_W];
    sq_side_t          sside[0:ROOT_W];

    logic              v3_reg;
    logic [QUO_W-1:0]  n1_reg, n2_reg, n1_next, n2_next;
    logic [DIV_W-1:0]  m_reg;
    dv_side_t          side3_reg, side3_next;
    logic signed [NUM_W-1:0] nb, sx36, num1, num2;
    logic [COEF_W-1:0] a_s;

    logic              dv  [0:QUO_W];
    logic [QUO_W-1:0]  dn1 [0:QUO_W];
    logic [QUO_W-1:0]  dn2 [0:QUO_W];
    logic [DIV_W-1:0]  dr1 [0:QUO_W];
    logic [DIV_W-1:0]  dr2 [0:QUO_W];
    logic [DIV_W-1:0]  dm  [0:QUO_W];
    dv_side_t          dside[0:QUO_W];

    logic              out_valid_reg;
    logic [1:0]        kind_reg;
    logic [OUT_W-1:0]  first_reg, second_reg, q1x, q2x, f_next, s_next;

    assign en       = out_ready || !out_valid_reg;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg        <= in_valid;
            v1_reg        <= v0_reg;
            v2_reg        <= v1_reg;
            v3_reg        <= sv[ROOT_W];
            out_valid_reg <= dv[QUO_W];
        end
    end

    always_comb
    begin
        mag_a = a0_reg[COEF_W-1] ? COEF_W'(-a0_reg) : a0_reg;
        mag_b = b0_reg[COEF_W-1] ? COEF_W'(-b0_reg) : b0_reg;
        mag_c = c0_reg[COEF_W-1] ? COEF_W'(-c0_reg) : c0_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a0_reg  <= coef_a;
            b0_reg  <= coef_b;
            c0_reg  <= coef_c;
            b2_reg  <= mag_b * mag_b;
            ac4_reg <= {32'(mag_a * mag_c), 2'b00};
            opp_reg <= (a0_reg[COEF_W-1] != c0_reg[COEF_W-1]) && (c0_reg != '0);
            a1_reg  <= a0_reg;
            b1_reg  <= b0_reg;
        end
    end

    always_comb
    begin
        b2x = {2'b00, b2_reg};
        if (opp_reg)
        begin
            d_next  = DISC_W'(b2x + ac4_reg);
            k2_next = KIND_DISTINCT;
        end
        else if (b2x > ac4_reg)
        begin
            d_next  = DISC_W'(b2x - ac4_reg);
            k2_next = KIND_DISTINCT;
        end
        else if (b2x < ac4_reg)
        begin
            d_next  = DISC_W'(ac4_reg - b2x);
            k2_next = KIND_COMPLEX;
        end
        else
        begin
            d_next  = '0;
            k2_next = KIND_EQUAL;
        end
        if (a1_reg == '0)
        begin
            k2_next = KIND_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg   <= d_next;
            k2_reg  <= k2_next;
            a2_reg  <= a1_reg;
            b2c_reg <= b1_reg;
        end
    end

    assign sv[0]    = v2_reg;
    assign sx[0]    = {1'b0, d_reg, {(2*FRAC_W){1'b0}}};
    assign srem[0]  = '0;
    assign sroot[0] = '0;
    assign sside[0] = '{kind: k2_reg, a: a2_reg, b: b2c_reg};

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_sqrt
        qrs_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (sv[i]),
            .x_in      (sx[i]),
            .rem_in    (srem[i]),
            .root_in   (sroot[i]),
            .side_in   (sside[i]),
            .valid_out (sv[i+1]),
            .x_out     (sx[i+1]),
            .rem_out   (srem[i+1]),
            .root_out  (sroot[i+1]),
            .side_out  (sside[i+1])
        );
    end

    always_comb
    begin
        a_s  = sside[ROOT_W].a;
        nb   = -($signed({{(NUM_W-COEF_W){sside[ROOT_W].b[COEF_W-1]}},
                          sside[ROOT_W].b}) <<< FRAC_W);
        sx36 = $signed({{(NUM_W-ROOT_W){1'b0}}, sroot[ROOT_W]});
        case (sside[ROOT_W].kind)
            KIND_DISTINCT:
            begin
                num1 = nb + sx36;
                num2 = nb - sx36;
            end
            KIND_COMPLEX:
            begin
                num1 = nb;
                num2 = sx36;
            end
            default:
            begin
                num1 = nb;
                num2 = nb;
            end
        endcase
        n1_next    = num1[NUM_W-1] ? QUO_W'(-num1) : QUO_W'(num1);
        n2_next    = num2[NUM_W-1] ? QUO_W'(-num2) : QUO_W'(num2);
        side3_next = '{kind: sside[ROOT_W].kind,
                       neg1: num1[NUM_W-1] ^ a_s[COEF_W-1],
                       neg2: num2[NUM_W-1] ^ a_s[COEF_W-1]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_reg    <= n1_next;
            n2_reg    <= n2_next;
            m_reg     <= a_s[COEF_W-1] ? {COEF_W'(-a_s), 1'b0} : {a_s, 1'b0};
            side3_reg <= side3_next;
        end
    end

    assign dv[0]    = v3_reg;
    assign dn1[0]   = n1_reg;
    assign dn2[0]   = n2_reg;
    assign dr1[0]   = '0;
    assign dr2[0]   = '0;
    assign dm[0]    = m_reg;
    assign dside[0] = side3_reg;

    for (genvar j = 0; j < QUO_W; j++)
    begin : g_div
        qrs_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (dv[j]),
            .n1_in     (dn1[j]),
            .n2_in     (dn2[j]),
            .r1_in     (dr1[j]),
            .r2_in     (dr2[j]),
            .m_in      (dm[j]),
            .side_in   (dside[j]),
            .valid_out (dv[j+1]),
            .n1_out    (dn1[j+1]),
            .n2_out    (dn2[j+1]),
            .r1_out    (dr1[j+1]),
            .r2_out    (dr2[j+1]),
            .m_out     (dm[j+1]),
            .side_out  (dside[j+1])
        );
    end

    always_comb
    begin
        q1x = {{(OUT_W-QUO_W){1'b0}}, dn1[QUO_W]};
        q2x = {{(OUT_W-QUO_W){1'b0}}, dn2[QUO_W]};
        f_next = dside[QUO_W].neg1 ? OUT_W'(-q1x) : q1x;
        s_next = dside[QUO_W].neg2 ? OUT_W'(-q2x) : q2x;
        if (dside[QUO_W].kind == KIND_NONE)
        begin
            f_next = '0;
            s_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind_reg   <= dside[QUO_W].kind;
            first_reg  <= f_next;
            second_reg <= s_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign root_kind    = kind_reg;
    assign first_value  = first_reg;
    assign second_value = second_reg;

endmodule
